FILE: src/slcb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the slotted collision backoff block.
// Used by slcb_lane, slcb_merge and slotted_collision_backoff; no dependencies.
package slcb_pkg;

    localparam int NUM_STATIONS  = 5;
    localparam int BACKOFF_CAP   = 10;
    localparam int MASK_BITS_MAX = 10;
    localparam int RAND_FIELDS   = 5;

    localparam int RAND_W    = 10;
    localparam int SLOT_W    = 16;
    localparam int TALLY_W   = 4;
    localparam int STATION_W = 3;
    localparam int MASK_W    = 5;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = $clog2(NUM_STATIONS + 1);

    localparam int IN_TDATA_W  = ((RAND_FIELDS * RAND_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = SLOT_W + 1 + STATION_W + 1 + MASK_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

    // Codes carried in the input tuser bit.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Slot outcome broadcast from the merge stage back to every lane.
    typedef struct packed {
        logic single;
        logic multi;
    } slot_ctrl_t;

    // One result word, first field in the lowest bits.
    typedef struct packed {
        logic                 all_sent;
        logic [MASK_W-1:0]    contender_mask;
        logic                 collided;
        logic [STATION_W-1:0] success_station;
        logic                 success_valid;
        logic [SLOT_W-1:0]    slot_number;
    } result_t;

endpackage

FILE: src/slotted_collision_backoff.sv
`timescale 1ns / 1ps
// Top level of the slotted collision backoff block: station lanes, merge stage,
// slot counter and a two-word output buffer. Depends on slcb_pkg, slcb_lane, slcb_merge.
//
//   Channel   Dir  tdata fields (low bit up)                          tuser
//   s_axis    in   rand_st0..rand_st4, 10 bits each, zero pad to 56   kind
//   m_axis    out  slot_number, success_valid, success_station,        -
//                  collided, contender_mask, all_sent, zero pad to 32
//
// Each input word is evaluated in the cycle it is accepted: every lane
// compares its schedule with the slot counter, the merge stage counts the
// contenders, and all station state and the counter update at that edge.
// A new word can be accepted every cycle while the skid word is empty; each result is registered.
// A second output register catches one result while the sink stalls, so the
// input stalls only once two results are waiting.
// Reset clears all station state, the slot counter and both output words.
module slotted_collision_backoff (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // rand_st0 [9:0], rand_st1 [19:10], rand_st2 [29:20], rand_st3 [39:30],
    // rand_st4 [49:40], zero [55:50]
    input  logic [slcb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // slot_number [15:0], success_valid [16], success_station [19:17],
    // collided [20], contender_mask [25:21], all_sent [26], zero [31:27]
    output logic [slcb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic accept;
    logic start;
    logic step;

    logic [slcb_pkg::SLOT_W-1:0] slot_reg, slot_next;

    logic [slcb_pkg::NUM_STATIONS-1:0] contend;
    logic [slcb_pkg::NUM_STATIONS-1:0] sent;
    slcb_pkg::slot_ctrl_t              ctrl;
    logic [slcb_pkg::STATION_W-1:0]    winner;
    logic [slcb_pkg::MASK_W-1:0]       mask;
    logic                              all_sent;

    slcb_pkg::result_t result;
    slcb_pkg::result_t out_reg, out_next;
    slcb_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && (s_axis_tuser == slcb_pkg::KIND_START);
    assign step          = accept && (s_axis_tuser == slcb_pkg::KIND_TICK);

    // One lane per station; stations beyond the input fields back off by zero.
    for (genvar i = 0; i < slcb_pkg::NUM_STATIONS; i++)
    begin : g_lane
        logic [slcb_pkg::RAND_W-1:0] lane_rand;

        if (i < slcb_pkg::RAND_FIELDS)
        begin : g_rand
            assign lane_rand = s_axis_tdata[i*slcb_pkg::RAND_W +: slcb_pkg::RAND_W];
        end
        else
        begin : g_zero
            assign lane_rand = '0;
        end

        slcb_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (step),
            .start     (start),
            .slot      (slot_reg),
            .rand_bits (lane_rand),
            .ctrl      (ctrl),
            .contend   (contend[i]),
            .sent      (sent[i])
        );
    end

    slcb_merge u_merge (
        .contend  (contend),
        .sent     (sent),
        .ctrl     (ctrl),
        .winner   (winner),
        .mask     (mask),
        .all_sent (all_sent)
    );

    // A start word answers with every field zero.
    always_comb
    begin
        if (s_axis_tuser == slcb_pkg::KIND_START)
        begin
            result = '0;
        end
        else
        begin
            result.slot_number     = slot_reg;
            result.success_valid   = ctrl.single;
            result.success_station = winner;
            result.collided        = ctrl.multi;
            result.contender_mask  = mask;
            result.all_sent        = all_sent;
        end
    end

    // The slot counter clears on start and saturates at its top value.
    always_comb
    begin
        slot_next = slot_reg;
        if (start)
        begin
            slot_next = '0;
        end
        else if (step && (slot_reg != slcb_pkg::SLOT_MAX))
        begin
            slot_next = slot_reg + slcb_pkg::SLOT_W'(1);
        end
    end

    // Output register with one skid word behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = accept;
            end
        end
        else if (accept)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else
        begin
            slot_reg       <= slot_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            out_reg        <= out_next;
            skid_reg       <= skid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = slcb_pkg::OUT_TDATA_W'(out_reg);

endmodule

FILE: src/slcb_lane.sv
`timescale 1ns / 1ps
// One station lane: holds the station's schedule, collision tally and sent flag,
// detects contention and applies the backoff update. Depends on slcb_pkg.
module slcb_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             start,
    input  logic [slcb_pkg::SLOT_W-1:0]      slot,
    input  logic [slcb_pkg::RAND_W-1:0]      rand_bits,
    input  slcb_pkg::slot_ctrl_t             ctrl,
    output logic                             contend,
    output logic                             sent
);

    logic [slcb_pkg::SLOT_W-1:0]  sched_reg, sched_next;
    logic [slcb_pkg::TALLY_W-1:0] tally_reg, tally_next;
    logic                         sent_reg, sent_next;

    logic [slcb_pkg::TALLY_W-1:0] tally_inc;
    logic [slcb_pkg::TALLY_W-1:0] mask_bits;
    logic [slcb_pkg::RAND_W:0]    bmask_wide;
    logic [slcb_pkg::RAND_W-1:0]  backoff;
    logic [slcb_pkg::SLOT_W:0]    resched_sum;
    logic [slcb_pkg::SLOT_W-1:0]  resched;

    assign contend = !sent_reg && (sched_reg == slot);
    assign sent    = sent_reg;

    always_comb
    begin
        tally_inc = (tally_reg < slcb_pkg::TALLY_W'(slcb_pkg::BACKOFF_CAP))
                    ? tally_reg + slcb_pkg::TALLY_W'(1) : tally_reg;
        mask_bits = (tally_inc > slcb_pkg::TALLY_W'(slcb_pkg::MASK_BITS_MAX))
                    ? slcb_pkg::TALLY_W'(slcb_pkg::MASK_BITS_MAX) : tally_inc;
        bmask_wide = ((slcb_pkg::RAND_W + 1)'(1) << mask_bits) - (slcb_pkg::RAND_W + 1)'(1);
        backoff    = rand_bits & bmask_wide[slcb_pkg::RAND_W-1:0];
        resched_sum = {1'b0, slot} + (slcb_pkg::SLOT_W + 1)'(1)
                    + (slcb_pkg::SLOT_W + 1)'(backoff);
        resched = resched_sum[slcb_pkg::SLOT_W] ? slcb_pkg::SLOT_MAX
                                                : resched_sum[slcb_pkg::SLOT_W-1:0];

        sched_next = sched_reg;
        tally_next = tally_reg;
        sent_next  = sent_reg;
        if (start)
        begin
            sched_next = '0;
            tally_next = '0;
            sent_next  = 1'b0;
        end
        else if (step && contend)
        begin
            if (ctrl.single)
            begin
                sent_next = 1'b1;
            end
            else if (ctrl.multi)
            begin
                tally_next = tally_inc;
                sched_next = resched;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_reg <= '0;
            tally_reg <= '0;
            sent_reg  <= 1'b0;
        end
        else
        begin
            sched_reg <= sched_next;
            tally_reg <= tally_next;
            sent_reg  <= sent_next;
        end
    end

endmodule

FILE: src/slcb_merge.sv
`timescale 1ns / 1ps
// Merge stage: counts the contending lanes, picks the winner and forms the
// slot outcome and status fields. Depends on slcb_pkg.
module slcb_merge (
    input  logic [slcb_pkg::NUM_STATIONS-1:0] contend,
    input  logic [slcb_pkg::NUM_STATIONS-1:0] sent,
    output slcb_pkg::slot_ctrl_t              ctrl,
    output logic [slcb_pkg::STATION_W-1:0]    winner,
    output logic [slcb_pkg::MASK_W-1:0]       mask,
    output logic                              all_sent
);

    logic [slcb_pkg::CNT_W-1:0] count;
    logic [slcb_pkg::IDX_W-1:0] win_idx;

    // The last contender found is the winner; it only matters when it is alone.
    always_comb
    begin
        count   = '0;
        win_idx = '0;
        for (int i = 0; i < slcb_pkg::NUM_STATIONS; i++)
        begin
            count = count + slcb_pkg::CNT_W'(contend[i]);
            if (contend[i])
            begin
                win_idx = slcb_pkg::IDX_W'(i);
            end
        end
        ctrl.single = (count == slcb_pkg::CNT_W'(1));
        ctrl.multi  = (count > slcb_pkg::CNT_W'(1));
        winner      = ctrl.single ? win_idx[slcb_pkg::STATION_W-1:0] : '0;
        all_sent    = &(sent | (ctrl.single ? contend : '0));
    end

    for (genvar b = 0; b < slcb_pkg::MASK_W; b++)
    begin : g_mask
        if (b < slcb_pkg::NUM_STATIONS)
        begin : g_live
            assign mask[b] = contend[b];
        end
        else
        begin : g_none
            assign mask[b] = 1'b0;
        end
    end

endmodule

FILE: tb/sv/slotted_collision_backoff_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for slotted_collision_backoff: a clocked driver, a clocked monitor
// and a cycle-free model of the five-station backoff medium. Depends on slcb_pkg and the RTL.
module slotted_collision_backoff_test;

    // Generous upper bound on the run; a correct run needs a small fraction of it.
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_WORDS = 540;
    // Ticks in the long round that drives every collision tally to its cap.
    localparam int SATURATION_TICKS = 40;
    localparam int DRAIN_CYCLES     = 8;

    typedef logic [slcb_pkg::RAND_FIELDS-1:0][slcb_pkg::RAND_W-1:0] backoff_bits_t;

    // One input word as queued for the driver. The hold flag makes the driver
    // wait until every outstanding result has come back before sending it.
    typedef struct packed {
        logic          kind;
        backoff_bits_t rnd;
        logic          hold;
    } medium_word_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // rand_st0 [9:0], rand_st1 [19:10], rand_st2 [29:20], rand_st3 [39:30],
    // rand_st4 [49:40], zero [55:50]
    logic [slcb_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // kind [0]
    logic                             s_axis_tuser = slcb_pkg::KIND_TICK;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // slot_number [15:0], success_valid [16], success_station [19:17],
    // collided [20], contender_mask [25:21], all_sent [26], zero [31:27]
    logic [slcb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    slotted_collision_backoff uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Words waiting to be sent, and results predicted for accepted words.
    medium_word_t      stim_words[$];
    slcb_pkg::result_t expected_results[$];
    int                words_total = 0;
    int                words_accepted = 0;
    int                mismatch_count = 0;
    int                cycle_count = 0;

    // Sender burst and gap bookkeeping.
    int burst_left = 0;
    int gap_left = 0;

    // Receiver stall pattern: a mode held for a random stretch of cycles.
    int ready_mode = 0;
    int mode_left = 0;

    // Model of the medium: slot counter and per-station schedule, tally and sent flag.
    logic [slcb_pkg::SLOT_W-1:0]  medium_slot;
    logic [slcb_pkg::SLOT_W-1:0]  station_sched [slcb_pkg::NUM_STATIONS];
    logic [slcb_pkg::TALLY_W-1:0] station_tally [slcb_pkg::NUM_STATIONS];
    logic                         station_sent  [slcb_pkg::NUM_STATIONS];

    function automatic void clear_medium();
        medium_slot = '0;
        for (int i = 0; i < slcb_pkg::NUM_STATIONS; i++)
        begin
            station_sched[i] = '0;
            station_tally[i] = '0;
            station_sent[i]  = 1'b0;
        end
    endfunction

    // Evaluates one word against the medium model, updates the model and
    // returns the result word that the block must produce for it.
    function automatic slcb_pkg::result_t advance_medium(input logic kind,
                                                         input backoff_bits_t rnd);
        slcb_pkg::result_t           res;
        logic [slcb_pkg::MASK_W-1:0] contenders;
        int                          num_contenders;
        int                          winner;
        int                          mask_bits;
        logic [slcb_pkg::RAND_W-1:0] offset;
        logic [slcb_pkg::SLOT_W:0]   next_slot;
        logic                        every_sent;
        res = '0;
        contenders = '0;
        num_contenders = 0;
        winner = 0;
        if (kind == slcb_pkg::KIND_START)
        begin
            // A start clears everything and answers with an all-zero word.
            clear_medium();
            return res;
        end
        for (int i = 0; i < slcb_pkg::NUM_STATIONS; i++)
        begin
            if (!station_sent[i] && station_sched[i] == medium_slot)
            begin
                contenders[i] = 1'b1;
                num_contenders++;
                winner = i;
            end
        end
        if (num_contenders == 1)
            station_sent[winner] = 1'b1;
        else if (num_contenders > 1)
        begin
            for (int i = 0; i < slcb_pkg::NUM_STATIONS; i++)
            begin
                if (contenders[i])
                begin
                    if (station_tally[i] < slcb_pkg::BACKOFF_CAP)
                        station_tally[i]++;
                    mask_bits = (station_tally[i] > slcb_pkg::MASK_BITS_MAX)
                                ? slcb_pkg::MASK_BITS_MAX : station_tally[i];
                    offset = (i < slcb_pkg::RAND_FIELDS) ? rnd[i] : '0;
                    offset = offset & slcb_pkg::RAND_W'((1 << mask_bits) - 1);
                    // The new schedule is computed one bit wider and held at the top slot.
                    next_slot = {1'b0, medium_slot} + 1 + offset;
                    station_sched[i] = (next_slot > slcb_pkg::SLOT_MAX)
                                       ? slcb_pkg::SLOT_MAX : next_slot[slcb_pkg::SLOT_W-1:0];
                end
            end
        end
        every_sent = 1'b1;
        for (int i = 0; i < slcb_pkg::NUM_STATIONS; i++)
            every_sent = every_sent & station_sent[i];
        res.slot_number     = medium_slot;
        res.success_valid   = (num_contenders == 1);
        res.success_station = (num_contenders == 1) ? slcb_pkg::STATION_W'(winner) : '0;
        res.collided        = (num_contenders > 1);
        res.contender_mask  = contenders;
        res.all_sent        = every_sent;
        if (medium_slot != slcb_pkg::SLOT_MAX)
            medium_slot++;
        return res;
    endfunction

    function automatic void queue_word(input logic kind, input backoff_bits_t rnd,
                                       input logic hold);
        medium_word_t w;
        w.kind = kind;
        w.rnd  = rnd;
        w.hold = hold;
        stim_words.push_back(w);
        words_total++;
    endfunction

    // Random backoff bits that mix the full range with small values and the
    // two extremes, so both short and long reschedules happen often.
    function automatic backoff_bits_t random_backoff_bits();
        backoff_bits_t rnd;
        for (int i = 0; i < slcb_pkg::RAND_FIELDS; i++)
        begin
            case ($urandom_range(0, 3))
                0:       rnd[i] = slcb_pkg::RAND_W'($urandom_range(0, 3));
                1:       rnd[i] = ($urandom_range(0, 1) == 0) ? '0 : '1;
                default: rnd[i] = slcb_pkg::RAND_W'($urandom_range(0, 1023));
            endcase
        end
        return rnd;
    endfunction

    // Driver: presents queued words in bursts with random gaps. A word stays
    // on the bus unchanged until it is accepted; a word is predicted at the
    // edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        medium_word_t w;
        logic         present;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= slcb_pkg::KIND_TICK;
            burst_left = 0;
            gap_left   = 0;
            clear_medium();
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                expected_results.push_back(advance_medium(s_axis_tuser,
                    s_axis_tdata[slcb_pkg::RAND_FIELDS*slcb_pkg::RAND_W-1:0]));
                words_accepted++;
            end
            if (burst_left == 0)
            begin
                if (gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    // About a third of the bursts run back to back with no gap.
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    gap_left--;
            end
            present = 1'b0;
            if (burst_left != 0 && stim_words.size() != 0)
            begin
                // A held word waits until every result so far has been checked.
                if (!stim_words[0].hold || expected_results.size() == 0)
                    present = 1'b1;
            end
            if (present)
            begin
                w = stim_words.pop_front();
                burst_left--;
                s_axis_tdata <= slcb_pkg::IN_TDATA_W'(w.rnd);
                s_axis_tuser <= w.kind;
            end
            s_axis_tvalid <= present;
        end
    end

    // Monitor: checks each result word against the oldest prediction and
    // drives the sink ready on a stall pattern of its own.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        slcb_pkg::result_t got;
        slcb_pkg::result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_mode = 0;
            mode_left  = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[slcb_pkg::OUT_FIELD_W-1:0];
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"ERROR: result word with none expected: ",
                                  "slot=%0d ok=%0b stn=%0d col=%0b mask=%b all=%0b"},
                                 got.slot_number, got.success_valid, got.success_station,
                                 got.collided, got.contender_mask, got.all_sent);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.slot_number !== want.slot_number ||
                        got.success_valid !== want.success_valid ||
                        got.success_station !== want.success_station ||
                        got.collided !== want.collided ||
                        got.contender_mask !== want.contender_mask ||
                        got.all_sent !== want.all_sent)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"ERROR: expected slot=%0d ok=%0b stn=%0d col=%0b ",
                                      "mask=%b all=%0b, got slot=%0d ok=%0b stn=%0d ",
                                      "col=%0b mask=%b all=%0b"},
                                     want.slot_number, want.success_valid,
                                     want.success_station, want.collided,
                                     want.contender_mask, want.all_sent,
                                     got.slot_number, got.success_valid,
                                     got.success_station, got.collided,
                                     got.contender_mask, got.all_sent);
                    end
                end
            end
            // Modes: always ready, mostly ready, and mostly stalled.
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(16, 160);
            end
            else
                mode_left--;
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : run_test
        int                          queued;
        int                          round_len;
        logic [slcb_pkg::RAND_W-1:0] shared;
        // Directed words. The first tick runs straight from reset: all five
        // stations collide in slot 0, and with zero random bits again in slot 1.
        queue_word(slcb_pkg::KIND_TICK, '0, 1'b0);
        queue_word(slcb_pkg::KIND_TICK, '0, 1'b0);
        // A start in the middle of a round clears it; its random bits are ignored.
        queue_word(slcb_pkg::KIND_START, '1, 1'b0);
        // Slot 0: everyone collides; station 0 draws 0 and the rest draw 1.
        queue_word(slcb_pkg::KIND_TICK, {10'd1, 10'd1, 10'd1, 10'd1, 10'd0}, 1'b0);
        // Slot 1: station 0 is alone and sends.
        queue_word(slcb_pkg::KIND_TICK, '1, 1'b0);
        // Slot 2: stations 1 to 4 collide again. Their high bits are set but
        // masked off, so they spread to slots 3, 4, 5 and 6.
        queue_word(slcb_pkg::KIND_TICK, {10'h3FF, 10'h3FE, 10'h3FD, 10'h3FC, 10'h3FF}, 1'b0);
        // Slots 3 to 6: one success each; the last one completes the round.
        for (int i = 0; i < 4; i++)
            queue_word(slcb_pkg::KIND_TICK, random_backoff_bits(), 1'b0);
        // Once every station has sent, ticks only advance the slot.
        queue_word(slcb_pkg::KIND_TICK, '0, 1'b0);
        queue_word(slcb_pkg::KIND_TICK, '1, 1'b0);
        // All-ones backoff: collide in slot 0, idle slot 1, collide in slot 2.
        queue_word(slcb_pkg::KIND_START, '1, 1'b0);
        queue_word(slcb_pkg::KIND_TICK, '1, 1'b0);
        queue_word(slcb_pkg::KIND_TICK, '1, 1'b0);
        queue_word(slcb_pkg::KIND_TICK, '1, 1'b0);

        // Long round: all stations draw the same small value, so they collide
        // often and never send, and every collision tally reaches its cap.
        queue_word(slcb_pkg::KIND_START, random_backoff_bits(), 1'b1);
        for (int k = 0; k < SATURATION_TICKS; k++)
        begin
            shared = slcb_pkg::RAND_W'($urandom_range(0, 3));
            queue_word(slcb_pkg::KIND_TICK, {slcb_pkg::RAND_FIELDS{shared}}, 1'b0);
        end

        // Random part: mostly rounds opened by a start, some without one, and
        // a little noise of random kinds.
        queued = 0;
        while (queued < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 5) != 0)
                begin
                    queue_word(slcb_pkg::KIND_START, random_backoff_bits(),
                               $urandom_range(0, 7) == 0);
                    queued++;
                end
                round_len = $urandom_range(3, 70);
                for (int k = 0; k < round_len; k++)
                    queue_word(slcb_pkg::KIND_TICK, random_backoff_bits(), 1'b0);
                queued += round_len;
            end
            else
            begin
                round_len = $urandom_range(1, 6);
                for (int k = 0; k < round_len; k++)
                    queue_word(1'($urandom_range(0, 1)), random_backoff_bits(), 1'b0);
                queued += round_len;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted != words_total)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // The drain wait catches any stray result word.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
